// File: hdl/v0k_pkg.sv
`default_nettype none
package v0k_pkg;
    localparam int MASS_W = 17;
    localparam int CFG_IW = 1;

    localparam logic [CFG_IW-1:0] REG_PION_MASS   = 1'b0;
    localparam logic [CFG_IW-1:0] REG_PROTON_MASS = 1'b1;

    localparam logic [MASS_W-1:0] PION_MASS_RST   = 17'd9147;
    localparam logic [MASS_W-1:0] PROTON_MASS_RST = 17'd61491;

    // multiplier chunk width and pipeline depth
    localparam int MUL_CW  = 32;
    localparam int MUL_LAT = 5;

    typedef logic signed [31:0] mom_t;

    typedef struct packed {
        logic ovf;
        logic neg;
    } alpha_flag_t;
endpackage
`default_nettype wire

// File: hdl/v0k_mul.sv
`default_nettype none
module v0k_mul
    import v0k_pkg::*;
#(
    parameter int W = 32
)(
    input  wire                   clk,
    input  wire                   en,
    input  wire signed [W-1:0]    a,
    input  wire signed [W-1:0]    b,
    output logic signed [2*W-1:0] p
);
    localparam int NC = (W + MUL_CW - 1) / MUL_CW;
    localparam int PW = NC * MUL_CW;

    logic [W-1:0]          a_mag;
    logic [W-1:0]          b_mag;
    logic [PW-1:0]         a_reg;
    logic [PW-1:0]         b_reg;
    logic [2*MUL_CW-1:0]   pp_reg   [NC][NC];
    logic [2*PW-1:0]       row_reg  [NC];
    logic [2*PW-1:0]       row_next [NC];
    logic [2*PW-1:0]       sum_reg;
    logic [2*PW-1:0]       sum_next;
    logic [3:0]            neg_reg;
    logic signed [2*W-1:0] p_reg;

    assign a_mag = a[W-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag = b[W-1] ? $unsigned(-b) : $unsigned(b);

    // partial products of 32-bit chunks, summed per row, then overall
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NC; j++)
            begin
                row_next[i] = row_next[i] + ((2*PW)'(pp_reg[i][j]) << (MUL_CW * (i + j)));
            end
        end
        sum_next = '0;
        for (int i = 0; i < NC; i++)
        begin
            sum_next = sum_next + row_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= PW'(a_mag);
            b_reg   <= PW'(b_mag);
            neg_reg <= {neg_reg[2:0], a[W-1] ^ b[W-1]};
            for (int i = 0; i < NC; i++)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    pp_reg[i][j] <= a_reg[i*MUL_CW +: MUL_CW] * b_reg[j*MUL_CW +: MUL_CW];
                end
                row_reg[i] <= row_next[i];
            end
            sum_reg <= sum_next;
            p_reg   <= neg_reg[3] ? -$signed(sum_reg[2*W-1:0]) : $signed(sum_reg[2*W-1:0]);
        end
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// File: hdl/v0k_sqrt.sv
`default_nettype none
module v0k_sqrt #(
    parameter int WI = 64
)(
    input  wire                    clk,
    input  wire                    en,
    input  wire [WI-1:0]           x,
    output logic [(WI+1)/2-1:0]    root
);
    localparam int WO = (WI + 1) / 2;
    localparam int RW = WO + 2;

    logic [2*WO-1:0] x_reg     [WO];
    logic [RW-1:0]   rem_reg   [WO];
    logic [WO-1:0]   root_reg  [WO];
    logic [2*WO-1:0] x_next    [WO];
    logic [RW-1:0]   rem_next  [WO];
    logic [WO-1:0]   root_next [WO];
    logic [2*WO-1:0] x_in      [WO];
    logic [RW-1:0]   rem_in    [WO];
    logic [WO-1:0]   root_in   [WO];
    logic [RW-1:0]   rin       [WO];
    logic [RW-1:0]   trial     [WO];

    // one root bit per stage
    always_comb
    begin
        for (int k = 0; k < WO; k++)
        begin
            if (k == 0)
            begin
                x_in[k]    = (2*WO)'(x);
                rem_in[k]  = '0;
                root_in[k] = '0;
            end
            else
            begin
                x_in[k]    = x_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            rin[k]   = {rem_in[k][RW-3:0], x_in[k][2*WO-1 -: 2]};
            trial[k] = {root_in[k], 2'b01};
            if (rin[k] >= trial[k])
            begin
                rem_next[k]  = rin[k] - trial[k];
                root_next[k] = {root_in[k][WO-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rin[k];
                root_next[k] = {root_in[k][WO-2:0], 1'b0};
            end
            x_next[k] = {x_in[k][2*WO-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < WO; k++)
            begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[WO-1];
endmodule
`default_nettype wire

// File: hdl/v0k_div.sv
`default_nettype none
module v0k_div #(
    parameter int DW = 66,
    parameter int QW = 64
)(
    input  wire           clk,
    input  wire           en,
    input  wire [DW-1:0]  hi,
    input  wire [QW-1:0]  lo,
    input  wire [DW-1:0]  den,
    output logic [QW-1:0] quo
);
    // hi must be below den; quotient shifts into lo
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] lo_next  [QW];
    logic [DW-1:0] r_in     [QW];
    logic [QW-1:0] l_in     [QW];
    logic [DW-1:0] d_in     [QW];
    logic [DW:0]   r2       [QW];
    logic [DW:0]   diff     [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                r_in[k] = hi;
                l_in[k] = lo;
                d_in[k] = den;
            end
            else
            begin
                r_in[k] = rem_reg[k-1];
                l_in[k] = lo_reg[k-1];
                d_in[k] = den_reg[k-1];
            end
            r2[k]   = {r_in[k], l_in[k][QW-1]};
            diff[k] = r2[k] - {1'b0, d_in[k]};
            if (r2[k] >= {1'b0, d_in[k]})
            begin
                rem_next[k] = diff[k][DW-1:0];
                lo_next[k]  = {l_in[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r2[k][DW-1:0];
                lo_next[k]  = {l_in[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                den_reg[k] <= d_in[k];
            end
        end
    end

    assign quo = lo_reg[QW-1];
endmodule
`default_nettype wire

// File: hdl/v0k_dly.sv
`default_nettype none
module v0k_dly #(
    parameter int W = 1,
    parameter int N = 1
)(
    input  wire          clk,
    input  wire          en,
    input  wire [W-1:0]  d,
    output logic [W-1:0] q
);
    logic [W-1:0] sh_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                sh_reg[k] <= sh_reg[k-1];
            end
        end
    end

    assign q = sh_reg[N-1];
endmodule
`default_nettype wire

// File: hdl/v0_two_body_kinematics.sv
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Depth is set by the 64-step root of the energy product and the 34-step mass root.
// Reset: valid bits cleared, mass registers return to pion and proton defaults.
// No clearing pass; requests are accepted from the first cycle after reset.
`default_nettype none
module v0_two_body_kinematics
    import v0k_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [CFG_IW-1:0]   cfg_index,
    input  wire [MASS_W-1:0]   cfg_data,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire signed [31:0]  first_px,
    input  wire signed [31:0]  first_py,
    input  wire signed [31:0]  first_pz,
    input  wire signed [31:0]  second_px,
    input  wire signed [31:0]  second_py,
    input  wire signed [31:0]  second_pz,
    input  wire                first_is_negative,
    output logic               out_valid,
    input  wire                out_ready,
    output logic               valid_res,
    output logic signed [23:0] alpha,
    output logic [31:0]        qt,
    output logic [31:0]        mass_two_pions,
    output logic [31:0]        mass_proton_pion,
    output logic [31:0]        mass_pion_antiproton
);
    localparam int LM = MUL_LAT;
    localparam int F  = 2 * LM + 102;
    localparam logic [23:0] ALPHA_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] ALPHA_NEG_MAG = 24'h800000;

    logic en;
    logic vld_reg [F+1];

    logic [MASS_W-1:0]   pion_mass_reg;
    logic [MASS_W-1:0]   proton_mass_reg;
    logic [2*MASS_W-1:0] psq_reg;
    logic [2*MASS_W-1:0] prsq_reg;
    logic [2*MASS_W:0]   msum_mix;

    // stage 0
    mom_t               in_a   [3];
    mom_t               in_b   [3];
    mom_t               pp_reg [3];
    mom_t               pm_reg [3];
    logic signed [32:0] s_reg  [3];
    logic               zero_s;
    logic               zero_f;

    // multiplier outputs
    logic signed [63:0] np_p  [3];
    logic signed [63:0] nm_p  [3];
    logic signed [63:0] dot_p [3];
    logic signed [63:0] crs_a [3];
    logic signed [63:0] crs_b [3];
    logic signed [65:0] s2_p  [3];

    // stage B
    logic [63:0]        np_b_reg;
    logic [63:0]        nm_b_reg;
    logic [65:0]        s2_b_reg;
    logic signed [65:0] dot_b_reg;
    logic signed [64:0] cx_b_reg [3];

    // stage C
    logic [63:0]        xa_pi_reg;
    logic [63:0]        xa_p_reg;
    logic [63:0]        xb_pi_reg;
    logic [63:0]        xb_p_reg;
    logic signed [64:0] dd_c_reg;
    logic signed [67:0] k_pipi_reg;
    logic signed [67:0] k_mix_reg;

    // alpha path
    logic [63:0]   mag_d_reg;
    logic          neg_d_reg;
    logic [65:0]   s2_d;
    logic          ovf_d;
    logic [65:0]   hi_e_reg;
    logic [23:0]   lo_e_reg;
    logic [65:0]   den_e_reg;
    alpha_flag_t   flag_e_reg;
    alpha_flag_t   flag_f;
    logic [23:0]   aq;
    logic [23:0]   aq_f;
    logic          a_sat;
    logic [23:0]   a_mag;

    // qt path
    logic signed [129:0] cxs_p [3];
    logic [127:0]        c2_reg;
    logic [65:0]         s2_q;
    logic [63:0]         q_quo;
    logic [31:0]         qt_root;
    logic [31:0]         qt_f;

    // mass paths
    logic signed [64:0]  xa_sel [3];
    logic signed [64:0]  xb_sel [3];
    logic signed [67:0]  k_sel  [3];
    logic signed [129:0] prod   [3];
    logic [63:0]         e_root [3];
    logic [67:0]         k_d    [3];
    logic signed [67:0]  m2_reg [3];
    logic [66:0]         m2_pos [3];
    logic [33:0]         m_root [3];
    logic [31:0]         m_sat  [3];

    // output stage
    logic               valid_res_reg;
    logic signed [23:0] alpha_reg;
    logic [31:0]        qt_reg;
    logic [31:0]        mass_reg [3];

    assign en        = !vld_reg[F] || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pion_mass_reg   <= PION_MASS_RST;
            proton_mass_reg <= PROTON_MASS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PION_MASS:   pion_mass_reg   <= cfg_data;
                REG_PROTON_MASS: proton_mass_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        psq_reg  <= pion_mass_reg * pion_mass_reg;
        prsq_reg <= proton_mass_reg * proton_mass_reg;
    end

    assign msum_mix = {1'b0, psq_reg} + {1'b0, prsq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= F; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= F; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 0: order into positive and negative, sum
    assign in_a[0] = first_px;
    assign in_a[1] = first_py;
    assign in_a[2] = first_pz;
    assign in_b[0] = second_px;
    assign in_b[1] = second_py;
    assign in_b[2] = second_pz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i] <= first_is_negative ? in_b[i] : in_a[i];
                pm_reg[i] <= first_is_negative ? in_a[i] : in_b[i];
                s_reg[i]  <= {in_a[i][31], in_a[i]} + {in_b[i][31], in_b[i]};
            end
        end
    end

    assign zero_s = (s_reg[0] == '0) && (s_reg[1] == '0) && (s_reg[2] == '0);

    v0k_dly #(.W(1), .N(F-1)) u_dly_zero (.clk, .en, .d(zero_s), .q(zero_f));

    for (genvar i = 0; i < 3; i++)
    begin : g_mul0
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        v0k_mul #(.W(32)) u_np  (.clk, .en, .a(pp_reg[i]), .b(pp_reg[i]), .p(np_p[i]));
        v0k_mul #(.W(32)) u_nm  (.clk, .en, .a(pm_reg[i]), .b(pm_reg[i]), .p(nm_p[i]));
        v0k_mul #(.W(32)) u_dot (.clk, .en, .a(pp_reg[i]), .b(pm_reg[i]), .p(dot_p[i]));
        v0k_mul #(.W(32)) u_ca  (.clk, .en, .a(pp_reg[J]), .b(pm_reg[L]), .p(crs_a[i]));
        v0k_mul #(.W(32)) u_cb  (.clk, .en, .a(pp_reg[L]), .b(pm_reg[J]), .p(crs_b[i]));
        v0k_mul #(.W(33)) u_s2  (.clk, .en, .a(s_reg[i]), .b(s_reg[i]), .p(s2_p[i]));
    end

    // stage B: sums and cross product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            np_b_reg  <= $unsigned(np_p[0]) + $unsigned(np_p[1]) + $unsigned(np_p[2]);
            nm_b_reg  <= $unsigned(nm_p[0]) + $unsigned(nm_p[1]) + $unsigned(nm_p[2]);
            s2_b_reg  <= $unsigned(s2_p[0]) + $unsigned(s2_p[1]) + $unsigned(s2_p[2]);
            dot_b_reg <= {{2{dot_p[0][63]}}, dot_p[0]} + {{2{dot_p[1][63]}}, dot_p[1]}
                       + {{2{dot_p[2][63]}}, dot_p[2]};
            for (int i = 0; i < 3; i++)
            begin
                cx_b_reg[i] <= {crs_a[i][63], crs_a[i]} - {crs_b[i][63], crs_b[i]};
            end
        end
    end

    // stage C: energy terms, norm difference, mass offsets
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_pi_reg  <= np_b_reg + {30'b0, psq_reg};
            xa_p_reg   <= np_b_reg + {30'b0, prsq_reg};
            xb_pi_reg  <= nm_b_reg + {30'b0, psq_reg};
            xb_p_reg   <= nm_b_reg + {30'b0, prsq_reg};
            dd_c_reg   <= {1'b0, np_b_reg} - {1'b0, nm_b_reg};
            k_pipi_reg <= {33'b0, psq_reg, 1'b0} - {dot_b_reg[65], dot_b_reg, 1'b0};
            k_mix_reg  <= {33'b0, msum_mix} - {dot_b_reg[65], dot_b_reg, 1'b0};
        end
    end

    // alpha
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_d_reg <= dd_c_reg[64] ? 64'(-dd_c_reg) : dd_c_reg[63:0];
            neg_d_reg <= dd_c_reg[64];
        end
    end

    v0k_dly #(.W(66), .N(2)) u_dly_s2a (.clk, .en, .d(s2_b_reg), .q(s2_d));

    // quotient reaches 2^24 exactly when the numerator's top part reaches the divisor
    assign ovf_d = {10'b0, mag_d_reg[63:8]} >= s2_d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_e_reg       <= ovf_d ? 66'd0 : {10'b0, mag_d_reg[63:8]};
            lo_e_reg       <= {mag_d_reg[7:0], 16'b0};
            den_e_reg      <= s2_d;
            flag_e_reg.ovf <= ovf_d;
            flag_e_reg.neg <= neg_d_reg;
        end
    end

    v0k_div #(.DW(66), .QW(24)) u_div_a (
        .clk, .en, .hi(hi_e_reg), .lo(lo_e_reg), .den(den_e_reg), .quo(aq)
    );

    v0k_dly #(.W(24), .N(LM+73)) u_dly_aq (.clk, .en, .d(aq), .q(aq_f));
    v0k_dly #(.W($bits(alpha_flag_t)), .N(LM+97)) u_dly_af (
        .clk, .en, .d(flag_e_reg), .q(flag_f)
    );

    // qt
    for (genvar i = 0; i < 3; i++)
    begin : g_cxs
        v0k_mul #(.W(65)) u_cxs (.clk, .en, .a(cx_b_reg[i]), .b(cx_b_reg[i]), .p(cxs_p[i]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= cxs_p[0][127:0] + cxs_p[1][127:0] + cxs_p[2][127:0];
        end
    end

    v0k_dly #(.W(66), .N(LM+1)) u_dly_s2q (.clk, .en, .d(s2_b_reg), .q(s2_q));

    v0k_div #(.DW(66), .QW(64)) u_div_q (
        .clk, .en, .hi({2'b0, c2_reg[127:64]}), .lo(c2_reg[63:0]), .den(s2_q), .quo(q_quo)
    );

    v0k_sqrt #(.WI(64)) u_sqrt_q (.clk, .en, .x(q_quo), .root(qt_root));

    v0k_dly #(.W(32), .N(3)) u_dly_qt (.clk, .en, .d(qt_root), .q(qt_f));

    // masses: pion-pion, proton-pion, pion-antiproton
    assign xa_sel[0] = $signed({1'b0, xa_pi_reg});
    assign xb_sel[0] = $signed({1'b0, xb_pi_reg});
    assign k_sel[0]  = k_pipi_reg;
    assign xa_sel[1] = $signed({1'b0, xa_p_reg});
    assign xb_sel[1] = $signed({1'b0, xb_pi_reg});
    assign k_sel[1]  = k_mix_reg;
    assign xa_sel[2] = $signed({1'b0, xa_pi_reg});
    assign xb_sel[2] = $signed({1'b0, xb_p_reg});
    assign k_sel[2]  = k_mix_reg;

    for (genvar h = 0; h < 3; h++)
    begin : g_mass
        v0k_mul #(.W(65)) u_ex (.clk, .en, .a(xa_sel[h]), .b(xb_sel[h]), .p(prod[h]));

        v0k_sqrt #(.WI(128)) u_sqrt_e (.clk, .en, .x(prod[h][127:0]), .root(e_root[h]));

        v0k_dly #(.W(68), .N(LM+64)) u_dly_k (.clk, .en, .d(k_sel[h]), .q(k_d[h]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m2_reg[h] <= $signed(k_d[h]) + $signed({3'b0, e_root[h], 1'b0});
            end
        end

        assign m2_pos[h] = (!m2_reg[h][67] && (m2_reg[h] != '0)) ? m2_reg[h][66:0] : 67'd0;

        v0k_sqrt #(.WI(67)) u_sqrt_m (.clk, .en, .x(m2_pos[h]), .root(m_root[h]));

        assign m_sat[h] = (m_root[h][33:32] != 2'b00) ? 32'hFFFF_FFFF : m_root[h][31:0];
    end

    // output stage
    assign a_sat = flag_f.ovf || aq_f[23];
    assign a_mag = flag_f.neg ? (a_sat ? ALPHA_NEG_MAG : aq_f)
                              : (a_sat ? ALPHA_POS_MAX : aq_f);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_f)
            begin
                valid_res_reg <= 1'b0;
                alpha_reg     <= '0;
                qt_reg        <= '0;
                for (int h = 0; h < 3; h++)
                begin
                    mass_reg[h] <= '0;
                end
            end
            else
            begin
                valid_res_reg <= 1'b1;
                alpha_reg     <= flag_f.neg ? $signed(24'd0 - a_mag) : $signed(a_mag);
                qt_reg        <= qt_f;
                for (int h = 0; h < 3; h++)
                begin
                    mass_reg[h] <= m_sat[h];
                end
            end
        end
    end

    assign out_valid            = vld_reg[F];
    assign valid_res            = valid_res_reg;
    assign alpha                = alpha_reg;
    assign qt                   = qt_reg;
    assign mass_two_pions       = mass_reg[0];
    assign mass_proton_pion     = mass_reg[1];
    assign mass_pion_antiproton = mass_reg[2];
endmodule
`default_nettype wire

// File: tb/v0k_checker.sv
`default_nettype none
module v0k_checker
    import v0k_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_valid,
    input  wire               cfg_ready,
    input  wire [CFG_IW-1:0]  cfg_index,
    input  wire [MASS_W-1:0]  cfg_data,
    input  wire               in_valid,
    input  wire               in_ready,
    input  wire signed [31:0] first_px,
    input  wire signed [31:0] first_py,
    input  wire signed [31:0] first_pz,
    input  wire signed [31:0] second_px,
    input  wire signed [31:0] second_py,
    input  wire signed [31:0] second_pz,
    input  wire               first_is_negative,
    input  wire               out_valid,
    input  wire               out_ready,
    input  wire               valid_res,
    input  wire signed [23:0] alpha,
    input  wire [31:0]        qt,
    input  wire [31:0]        mass_two_pions,
    input  wire [31:0]        mass_proton_pion,
    input  wire [31:0]        mass_pion_antiproton,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic        ok;
        logic [23:0] alpha;
        logic [31:0] qt;
        logic [31:0] m_pipi;
        logic [31:0] m_ppi;
        logic [31:0] m_pipbar;
    } kin_t;

    kin_t        kin_q[$];
    logic [16:0] pi_m;
    logic [16:0] pr_m;

    function automatic wide_t root_floor(input wide_t a);
        wide_t r;
        wide_t c;
        r = 0;
        for (int k = 127; k >= 0; k--)
        begin
            c = r | (wide_t'(1) << k);
            if ($unsigned(c * c) <= $unsigned(a))
                r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clip32(input wide_t a);
        if (a > wide_t'(64'hFFFF_FFFF))
            return 32'hFFFF_FFFF;
        return a[31:0];
    endfunction

    function automatic wide_t dot(input longint a[3], input longint b[3]);
        wide_t acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += wide_t'(a[i]) * wide_t'(b[i]);
        return acc;
    endfunction

    function automatic logic [31:0] inv_mass(input longint a[3], input longint b[3],
                                             input logic [16:0] ma, input logic [16:0] mb);
        wide_t ma2;
        wide_t mb2;
        wide_t pe;
        wide_t m2;
        ma2 = wide_t'(ma) * wide_t'(ma);
        mb2 = wide_t'(mb) * wide_t'(mb);
        pe = root_floor((dot(a, a) + ma2) * (dot(b, b) + mb2));
        m2 = ma2 + mb2 + 2 * pe - 2 * dot(a, b);
        if (m2 <= 0)
            return 0;
        return clip32(root_floor(m2));
    endfunction

    function automatic kin_t kinematics(input longint d1[3], input longint d2[3],
                                        input logic neg_first);
        kin_t   r;
        longint pp[3];
        longint pm[3];
        longint s[3];
        wide_t  s2;
        wide_t  dd;
        wide_t  q;
        wide_t  c2;
        wide_t  cx;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            pp[i] = neg_first ? d2[i] : d1[i];
            pm[i] = neg_first ? d1[i] : d2[i];
        end
        for (int i = 0; i < 3; i++)
            s[i] = pp[i] + pm[i];
        if (s[0] == 0 && s[1] == 0 && s[2] == 0)
            return r;
        r.ok = 1'b1;
        s2 = dot(s, s);
        dd = dot(pp, pp) - dot(pm, pm);
        q = ((dd < 0 ? -dd : dd) * 65536) / s2;
        if (dd < 0)
        begin
            if (q > 8388608)
                q = 8388608;
            r.alpha = 24'(-q);
        end
        else
            r.alpha = (q > 8388607) ? 24'd8388607 : q[23:0];
        c2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            cx = wide_t'(pp[(i+1)%3]) * wide_t'(pm[(i+2)%3])
               - wide_t'(pp[(i+2)%3]) * wide_t'(pm[(i+1)%3]);
            c2 += cx * cx;
        end
        r.qt = clip32(root_floor(c2 / s2));
        r.m_pipi = inv_mass(d1, d2, pi_m, pi_m);
        r.m_ppi = inv_mass(pp, pm, pr_m, pi_m);
        r.m_pipbar = inv_mass(pp, pm, pi_m, pr_m);
        return r;
    endfunction

    assign pending = kin_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        kin_t   e;
        longint d1[3];
        longint d2[3];
        if (!rst_n)
        begin
            pi_m = PION_MASS_RST;
            pr_m = PROTON_MASS_RST;
            kin_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PION_MASS)
                    pi_m = cfg_data;
                else if (cfg_index == REG_PROTON_MASS)
                    pr_m = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                d1 = '{longint'(first_px), longint'(first_py), longint'(first_pz)};
                d2 = '{longint'(second_px), longint'(second_py), longint'(second_pz)};
                kin_q = {kin_q, kinematics(d1, d2, first_is_negative)};
            end
            if (out_valid && out_ready)
            begin
                if (kin_q.size() == 0)
                begin
                    $error("unexpected result");
                    errors++;
                end
                else
                begin
                    e = kin_q.pop_front();
                    if (valid_res !== e.ok)
                    begin
                        $error("valid_res exp %0d got %0d", e.ok, valid_res);
                        errors++;
                    end
                    if (alpha !== e.alpha)
                    begin
                        $error("alpha exp %0d got %0d", $signed(e.alpha), alpha);
                        errors++;
                    end
                    if (qt !== e.qt)
                    begin
                        $error("qt exp %0d got %0d", e.qt, qt);
                        errors++;
                    end
                    if (mass_two_pions !== e.m_pipi)
                    begin
                        $error("mass_two_pions exp %0d got %0d", e.m_pipi, mass_two_pions);
                        errors++;
                    end
                    if (mass_proton_pion !== e.m_ppi)
                    begin
                        $error("mass_proton_pion exp %0d got %0d", e.m_ppi, mass_proton_pion);
                        errors++;
                    end
                    if (mass_pion_antiproton !== e.m_pipbar)
                    begin
                        $error("mass_pion_antiproton exp %0d got %0d", e.m_pipbar,
                               mass_pion_antiproton);
                        errors++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    import v0k_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index = '0;
    logic [MASS_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] first_px = '0;
    logic signed [31:0] first_py = '0;
    logic signed [31:0] first_pz = '0;
    logic signed [31:0] second_px = '0;
    logic signed [31:0] second_py = '0;
    logic signed [31:0] second_pz = '0;
    logic               first_is_negative = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               valid_res;
    logic signed [23:0] alpha;
    logic [31:0]        qt;
    logic [31:0]        mass_two_pions;
    logic [31:0]        mass_proton_pion;
    logic [31:0]        mass_pion_antiproton;
    int                 errors;
    int                 pending;
    logic               steady = 1'b0;
    logic               squeeze = 1'b0;

    v0_two_body_kinematics dut (.*);
    v0k_checker chk (.*);

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off, clean while steady
    initial
    begin
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !held)
            begin
                held = 1'b1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 29);
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [MASS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending != 0)
            @(posedge clk);
        repeat (130)
            @(posedge clk);
    endtask

    task automatic send_pair(input logic [31:0] a[3], input logic [31:0] b[3],
                             input logic neg);
        if (!steady && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        first_px <= a[0];
        first_py <= a[1];
        first_pz <= a[2];
        second_px <= b[0];
        second_py <= b[1];
        second_pz <= b[2];
        first_is_negative <= neg;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] pick_comp(input int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            1: return $urandom;
            default:
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    task automatic random_pairs(input int n);
        logic [31:0] a[3];
        logic [31:0] b[3];
        int          mode;
        int          r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            mode = (r < 60) ? 0 : (r < 85) ? 1 : 2;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = pick_comp(mode);
                b[i] = pick_comp(mode);
            end
            if ($urandom_range(0, 99) < 8)
                for (int i = 0; i < 3; i++)
                    b[i] = -a[i];
            send_pair(a, b, 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] mx[3];
        logic [31:0] mn[3];
        logic [31:0] zr[3];
        logic [31:0] ax[3];
        logic [31:0] ng[3];
        mx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        zr = '{32'h0, 32'h0, 32'h0};
        ax = '{32'h0, 32'h0, 32'h0001_0000};
        ng = '{32'h0, 32'h0, 32'hFFFF_0000};
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sum, extremes, both orderings, collinear pair
        send_pair(zr, zr, 1'b0);
        send_pair(ax, ng, 1'b0);
        send_pair(ax, ng, 1'b1);
        send_pair(mx, mx, 1'b0);
        send_pair(mn, mn, 1'b1);
        send_pair(mx, mn, 1'b0);
        send_pair(mn, mx, 1'b1);
        send_pair(mx, zr, 1'b0);
        send_pair(zr, mn, 1'b1);
        send_pair(ax, ax, 1'b0);
        send_pair(ax, zr, 1'b1);
        send_pair('{32'h0001_0000, 32'h0, 32'h0}, '{32'h0, 32'h0002_0000, 32'h0}, 1'b0);
        in_valid <= 1'b0;
        @(posedge clk);
        random_pairs(300);
        drain();

        // massless daughters: collinear pairs give zero squared mass
        write_reg(REG_PION_MASS, 17'd0);
        write_reg(REG_PROTON_MASS, 17'd0);
        send_pair(ax, ax, 1'b0);
        send_pair(mx, mx, 1'b1);
        in_valid <= 1'b0;
        @(posedge clk);
        random_pairs(150);
        drain();

        write_reg(REG_PION_MASS, 17'h1FFFF);
        write_reg(REG_PROTON_MASS, 17'h1FFFF);
        send_pair(mx, mn, 1'b0);
        random_pairs(150);
        drain();

        write_reg(REG_PION_MASS, 17'($urandom));
        write_reg(REG_PROTON_MASS, 17'($urandom));
        steady = 1'b1;
        random_pairs(300);
        steady = 1'b0;
        drain();

        // receiver stalls for a long stretch while requests keep coming
        write_reg(REG_PROTON_MASS, PROTON_MASS_RST);
        write_reg(REG_PION_MASS, PION_MASS_RST);
        squeeze = 1'b1;
        random_pairs(330);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// File: v0_two_body_kinematics.f
hdl/v0k_pkg.sv
hdl/v0k_mul.sv
hdl/v0k_sqrt.sv
hdl/v0k_div.sv
hdl/v0k_dly.sv
hdl/v0_two_body_kinematics.sv
tb/v0k_checker.sv
tb/testbench.sv
